[design/height_spectral_colormap_core_defines.svh]
// ============================================================================
// Assertion macros for the height spectral colormap core
// Shared concurrent assertion wrappers; they expand to nothing in synthesis.
// ============================================================================
`ifndef HEIGHT_SPECTRAL_COLORMAP_CORE_DEFINES_SVH
`define HEIGHT_SPECTRAL_COLORMAP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define HSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsc assertion failed");
`define HSC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hsc assertion failed");
`else
`define HSC_ASSERT(lbl, clk, rst_n, prop)
`define HSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[design/hsc_pkg.sv]
// ============================================================================
// hsc_pkg
// Formats, stop table and segment constants of the height colormap pipeline.
// ============================================================================
`default_nettype none

package hsc_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int HEIGHT_W    = 20;
    localparam int MAG_W       = HEIGHT_W - 1;
    localparam int CHAN_W      = 8;
    localparam int CHAN_COUNT  = 3;
    localparam int STOP_COUNT  = 10;
    localparam int SEG_COUNT   = STOP_COUNT - 1;
    localparam int SEG_W       = $clog2(STOP_COUNT);
    localparam int POS_W       = 7;
    localparam int STOP_SCALE  = 100;
    localparam int SCALED_W    = MAG_W + POS_W;
    localparam int SPAN_W      = 4;
    localparam int N_W         = FRAC_BITS + SPAN_W;
    localparam int NUM_W       = N_W + CHAN_W;
    localparam int X_W         = NUM_W - FRAC_BITS;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam int GRAY_W      = MAG_W + CHAN_W;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_LOW    = 2'd0;
    localparam t_kind KIND_WHITE  = 2'd1;
    localparam t_kind KIND_GRAY   = 2'd2;
    localparam t_kind KIND_INTERP = 2'd3;

    typedef struct packed {
        t_kind              kind;
        logic [SEG_W-1:0]   seg;
        logic [N_W-1:0]     n;
        logic [CHAN_W-1:0]  gray;
        logic               last;
    } t_seg_word;

    localparam logic [POS_W-1:0] STOP_POS [0:STOP_COUNT-1] = '{
        7'd0, 7'd12, 7'd24, 7'd38, 7'd52, 7'd66, 7'd78, 7'd88, 7'd95, 7'd100
    };

    localparam logic [CHAN_W-1:0] STOP_RGB [0:STOP_COUNT-1][0:CHAN_COUNT-1] = '{
        '{8'd0,   8'd8,   8'd92},
        '{8'd0,   8'd84,  8'd196},
        '{8'd0,   8'd232, 8'd255},
        '{8'd0,   8'd168, 8'd74},
        '{8'd244, 8'd235, 8'd60},
        '{8'd255, 8'd164, 8'd32},
        '{8'd228, 8'd42,  8'd24},
        '{8'd118, 8'd72,  8'd42},
        '{8'd132, 8'd86,  8'd178},
        '{8'd255, 8'd255, 8'd255}
    };

    localparam logic [SPAN_W-1:0] SEG_SPAN [0:SEG_COUNT-1] = '{
        4'd12, 4'd12, 4'd14, 4'd14, 4'd14, 4'd12, 4'd10, 4'd7, 4'd5
    };

    // Rounded-up reciprocals; exact floor division for every blend quotient.
    localparam logic [RECIP_W-1:0] SEG_RECIP [0:SEG_COUNT-1] = '{
        RECIP_W'(((2 ** RECIP_SHIFT) + 11) / 12),
        RECIP_W'(((2 ** RECIP_SHIFT) + 11) / 12),
        RECIP_W'(((2 ** RECIP_SHIFT) + 13) / 14),
        RECIP_W'(((2 ** RECIP_SHIFT) + 13) / 14),
        RECIP_W'(((2 ** RECIP_SHIFT) + 13) / 14),
        RECIP_W'(((2 ** RECIP_SHIFT) + 11) / 12),
        RECIP_W'(((2 ** RECIP_SHIFT) + 9) / 10),
        RECIP_W'(((2 ** RECIP_SHIFT) + 6) / 7),
        RECIP_W'(((2 ** RECIP_SHIFT) + 4) / 5)
    };

endpackage

`default_nettype wire

[design/hsc_front.sv]
// ============================================================================
// hsc_front
// Scales the height, finds its colormap segment and the offset within it.
// ============================================================================
`default_nettype none

`include "height_spectral_colormap_core_defines.svh"

module hsc_front
    import hsc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire logic                       i_valid,
    input  wire logic signed [HEIGHT_W-1:0] i_height_sample,
    input  wire logic                       i_last_pixel,
    input  wire logic                       i_color_mode,
    output logic                            o_valid,
    output t_seg_word                       o_word
);

    logic                r_s1_valid;
    logic [SCALED_W-1:0] r_s1_scaled;
    logic                r_s1_low;
    logic                r_s1_mode;
    logic [CHAN_W-1:0]   r_s1_gray;
    logic                r_s1_last;

    logic                r_s2_valid;
    t_seg_word           r_s2_word;

    logic [MAG_W-1:0]    w_mag;
    logic                w_low;
    logic                w_sat;
    logic [SCALED_W-1:0] w_scaled;
    logic [GRAY_W-1:0]   w_gray_prod;
    logic [CHAN_W-1:0]   n_s1_gray;
    t_seg_word           n_s2_word;

    always_comb begin
        w_mag       = i_height_sample[MAG_W-1:0];
        w_low       = i_height_sample[HEIGHT_W-1] || (w_mag == '0);
        w_sat       = |(w_mag >> FRAC_BITS);
        w_scaled    = SCALED_W'(w_mag) * SCALED_W'(STOP_SCALE);
        w_gray_prod = GRAY_W'(w_mag) * GRAY_W'(255);
        if (w_low) begin
            n_s1_gray = '0;
        end else if (w_sat) begin
            n_s1_gray = '1;
        end else begin
            n_s1_gray = w_gray_prod[FRAC_BITS +: CHAN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_scaled <= w_scaled;
            r_s1_low    <= w_low;
            r_s1_mode   <= i_color_mode;
            r_s1_gray   <= n_s1_gray;
            r_s1_last   <= i_last_pixel;
            r_s2_word   <= n_s2_word;
        end
    end

    // The first stop at or above the height closes the segment.
    always_comb begin
        logic             found;
        logic [SEG_W-1:0] seg;
        found = 1'b0;
        seg   = '0;
        for (int i = STOP_COUNT - 1; i >= 1; i--) begin
            if (r_s1_scaled <= (SCALED_W'(STOP_POS[i]) << FRAC_BITS)) begin
                found = 1'b1;
                seg   = SEG_W'(i - 1);
            end
        end
        n_s2_word.seg  = seg;
        n_s2_word.n    = N_W'(r_s1_scaled - (SCALED_W'(STOP_POS[seg]) << FRAC_BITS));
        n_s2_word.gray = r_s1_gray;
        n_s2_word.last = r_s1_last;
        priority if (r_s1_mode) begin
            n_s2_word.kind = KIND_GRAY;
        end else if (r_s1_low) begin
            n_s2_word.kind = KIND_LOW;
        end else if (!found) begin
            n_s2_word.kind = KIND_WHITE;
        end else begin
            n_s2_word.kind = KIND_INTERP;
        end
    end

    assign o_valid = r_s2_valid;
    assign o_word  = r_s2_word;

    `HSC_ASSERT(a_interp_offset, i_clk, i_rst_n, r_s2_valid && (r_s2_word.kind == KIND_INTERP) |-> (r_s2_word.n != '0) && (r_s2_word.seg < SEG_W'(SEG_COUNT)))

endmodule

`default_nettype wire

[design/hsc_blend.sv]
// ============================================================================
// hsc_blend
// Blends the two stop colors of a segment per channel and selects the pixel.
// ============================================================================
`default_nettype none

`include "height_spectral_colormap_core_defines.svh"

module hsc_blend
    import hsc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_en,
    input  wire logic         i_valid,
    input  wire t_seg_word    i_word,
    output logic              o_valid,
    output logic [CHAN_W-1:0] o_red,
    output logic [CHAN_W-1:0] o_green,
    output logic [CHAN_W-1:0] o_blue,
    output logic              o_last
);

    logic              r_s3_valid;
    t_kind             r_s3_kind;
    logic [SEG_W-1:0]  r_s3_seg;
    logic [CHAN_W-1:0] r_s3_gray;
    logic              r_s3_last;
    logic [X_W-1:0]    r_s3_x   [0:CHAN_COUNT-1];

    logic              r_s4_valid;
    logic              r_s4_last;
    logic [CHAN_W-1:0] r_s4_rgb [0:CHAN_COUNT-1];

    logic [N_W-1:0]    w_span;
    logic [N_W-1:0]    w_rest;

    assign w_span = N_W'(SEG_SPAN[i_word.seg]) << FRAC_BITS;
    assign w_rest = w_span - i_word.n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (i_en) begin
            r_s3_valid <= i_valid;
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_kind <= i_word.kind;
            r_s3_seg  <= i_word.seg;
            r_s3_gray <= i_word.gray;
            r_s3_last <= i_word.last;
            r_s4_last <= r_s3_last;
        end
    end

    for (genvar c = 0; c < CHAN_COUNT; c++) begin : g_lane
        logic [CHAN_W-1:0] w_ca;
        logic [CHAN_W-1:0] w_cb;
        logic [NUM_W-1:0]  w_num;
        logic [X_W-1:0]    n_s3_x;
        logic [PROD_W-1:0] w_prod;
        logic [CHAN_W-1:0] n_s4_rgb;

        assign w_ca   = STOP_RGB[i_word.seg][c];
        assign w_cb   = STOP_RGB[SEG_W'(i_word.seg + 1'b1)][c];
        assign w_num  = NUM_W'(w_ca) * NUM_W'(w_rest) + NUM_W'(w_cb) * NUM_W'(i_word.n);
        assign n_s3_x = w_num[NUM_W-1:FRAC_BITS];
        assign w_prod = PROD_W'(r_s3_x[c]) * PROD_W'(SEG_RECIP[r_s3_seg]);

        always_comb begin
            unique case (r_s3_kind)
                KIND_LOW:    n_s4_rgb = STOP_RGB[0][c];
                KIND_WHITE:  n_s4_rgb = '1;
                KIND_GRAY:   n_s4_rgb = r_s3_gray;
                KIND_INTERP: n_s4_rgb = w_prod[RECIP_SHIFT +: CHAN_W];
            endcase
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s3_x[c]   <= n_s3_x;
                r_s4_rgb[c] <= n_s4_rgb;
            end
        end
    end

    assign o_valid = r_s4_valid;
    assign o_last  = r_s4_last;
    assign o_red   = r_s4_rgb[0];
    assign o_green = r_s4_rgb[1];
    assign o_blue  = r_s4_rgb[2];

    for (genvar c = 0; c < CHAN_COUNT; c++) begin : g_check
        `HSC_ASSERT(a_blend_range, i_clk, i_rst_n, r_s3_valid && (r_s3_kind == KIND_INTERP) |-> (r_s3_x[c] <= X_W'(SEG_SPAN[r_s3_seg]) * X_W'(255)))
    end

    `HSC_ASSERT(a_gray_equal, i_clk, i_rst_n, i_en && r_s3_valid && (r_s3_kind == KIND_GRAY) |=> (o_red == o_green) && (o_green == o_blue))

endmodule

`default_nettype wire

[design/height_spectral_colormap_core.sv]
// ============================================================================
// height_spectral_colormap_core
// Maps one fixed-point height word to one RGB pixel, spectral or gray.
// Throughput is one word per unstalled cycle through a four-stage pipeline.
// A stall on the output holds every stage; bubbles pass through.
// Reset clears all stage valid bits and selects the spectral colormap.
// ============================================================================
`default_nettype none

`include "height_spectral_colormap_core_defines.svh"

module height_spectral_colormap_core
    import hsc_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_wdata,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [HEIGHT_W-1:0] i_height_sample,
    input  wire logic                       i_last_pixel,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic [CHAN_W-1:0]               o_red,
    output logic [CHAN_W-1:0]               o_green,
    output logic [CHAN_W-1:0]               o_blue,
    output logic                            o_last_pixel_out
);

    logic      r_color_mode;
    logic      w_en;
    logic      w_front_valid;
    t_seg_word w_front_word;

    assign w_en    = !(i_stall && o_valid);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_color_mode <= i_cfg_wdata;
        end
    end

    hsc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_en            (w_en),
        .i_valid         (i_valid),
        .i_height_sample (i_height_sample),
        .i_last_pixel    (i_last_pixel),
        .i_color_mode    (r_color_mode),
        .o_valid         (w_front_valid),
        .o_word          (w_front_word)
    );

    hsc_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_word  (w_front_word),
        .o_valid (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue),
        .o_last  (o_last_pixel_out)
    );

    `HSC_ASSERT_ALWAYS(a_reset_flush, i_clk, !i_rst_n |=> !o_valid && !w_front_valid)

endmodule

`default_nettype wire

[tb/height_spectral_colormap_core_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// height_spectral_colormap_core_tb
// Streams height words through the colormap core in both color modes and
// checks every pixel word against a cycle-free predictor of the colormap.
// Both handshake sides idle at random, and the mode register is rewritten
// between drained phases.
// ============================================================================

module height_spectral_colormap_core_tb;

    import hsc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 950;
    localparam int PHASE_COUNT  = 6;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last_flag;
    } pixel_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height;
        logic                       last_flag;
    } height_word_t;

    typedef struct {
        int pos;
        int r;
        int g;
        int b;
    } color_stop_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic                       i_cfg_wdata = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [HEIGHT_W-1:0] i_height_sample = '0;
    logic                       i_last_pixel = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [CHAN_W-1:0]          o_red;
    logic [CHAN_W-1:0]          o_green;
    logic [CHAN_W-1:0]          o_blue;
    logic                       o_last_pixel_out;

    height_word_t height_queue[$];
    pixel_t       expected_pixels[$];
    logic         color_mode = 1'b0;
    bit           quiet_phase = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           words_sent = 0;
    int           words_checked = 0;
    int           mode_writes = 0;
    int           error_count = 0;
    int           cycle_count = 0;

    height_spectral_colormap_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_height_sample  (i_height_sample),
        .i_last_pixel     (i_last_pixel),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_red            (o_red),
        .o_green          (o_green),
        .o_blue           (o_blue),
        .o_last_pixel_out (o_last_pixel_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic color_stop_t color_stop(int idx);
        color_stop_t s;
        case (idx)
            0: s = '{0, 0, 8, 92};
            1: s = '{12, 0, 84, 196};
            2: s = '{24, 0, 232, 255};
            3: s = '{38, 0, 168, 74};
            4: s = '{52, 244, 235, 60};
            5: s = '{66, 255, 164, 32};
            6: s = '{78, 228, 42, 24};
            7: s = '{88, 118, 72, 42};
            8: s = '{95, 132, 86, 178};
            default: s = '{100, 255, 255, 255};
        endcase
        return s;
    endfunction

    function automatic logic [CHAN_W-1:0] blend(int ca, int cb, longint n, longint d);
        longint num;
        num = longint'(ca) * (d - n) + longint'(cb) * n;
        return CHAN_W'(num / d);
    endfunction

    function automatic pixel_t colormap_pixel(logic signed [HEIGHT_W-1:0] h, logic last_flag,
                                              logic mode);
        pixel_t      px;
        longint      hv;
        longint      scaled;
        longint      lo_pos;
        longint      hi_pos;
        longint      gray;
        color_stop_t sa;
        color_stop_t sb;
        bit          found;
        hv = longint'(h);
        found = 1'b0;
        if (mode) begin
            if (hv <= 0) gray = 0;
            else if (hv >= (longint'(1) << FRAC_BITS)) gray = 255;
            else gray = (hv * 255) >> FRAC_BITS;
            px.red = CHAN_W'(gray);
            px.green = CHAN_W'(gray);
            px.blue = CHAN_W'(gray);
        end else if (hv <= 0) begin
            sa = color_stop(0);
            px.red = CHAN_W'(sa.r);
            px.green = CHAN_W'(sa.g);
            px.blue = CHAN_W'(sa.b);
        end else begin
            px.red = '1;
            px.green = '1;
            px.blue = '1;
            scaled = hv * 100;
            for (int i = 1; i < 10; i++) begin
                sb = color_stop(i);
                hi_pos = longint'(sb.pos) << FRAC_BITS;
                if (!found && scaled <= hi_pos) begin
                    found = 1'b1;
                    sa = color_stop(i - 1);
                    lo_pos = longint'(sa.pos) << FRAC_BITS;
                    px.red = blend(sa.r, sb.r, scaled - lo_pos, hi_pos - lo_pos);
                    px.green = blend(sa.g, sb.g, scaled - lo_pos, hi_pos - lo_pos);
                    px.blue = blend(sa.b, sb.b, scaled - lo_pos, hi_pos - lo_pos);
                end
            end
        end
        px.last_flag = last_flag;
        return px;
    endfunction

    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet_phase || pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] random_height();
        int          pick;
        color_stop_t s;
        pick = $urandom_range(0, 99);
        if (pick < 45) return HEIGHT_W'($urandom_range(1, 1 << FRAC_BITS));
        if (pick < 57) begin
            s = color_stop($urandom_range(0, 9));
            return HEIGHT_W'(((s.pos << FRAC_BITS) / 100) + $urandom_range(0, 6) - 3);
        end
        if (pick < 65) return -HEIGHT_W'($urandom_range(0, 1000));
        return HEIGHT_W'($urandom());
    endfunction

    task automatic push_height(logic signed [HEIGHT_W-1:0] h, logic last_flag);
        height_word_t w;
        w.height = h;
        w.last_flag = last_flag;
        height_queue.insert(height_queue.size(), w);
    endtask

    task automatic write_mode(logic mode);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        color_mode = mode;
        mode_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (height_queue.size() != 0 || i_valid || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : driver
        height_word_t w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_pixels.insert(expected_pixels.size(),
                                       colormap_pixel(i_height_sample, i_last_pixel,
                                                      color_mode));
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (send_gap != 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (height_queue.size() != 0) begin
                    w = height_queue.pop_front();
                    i_valid <= 1'b1;
                    i_height_sample <= w.height;
                    i_last_pixel <= w.last_flag;
                    send_gap = idle_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        pixel_t got;
        pixel_t want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_red, o_green, o_blue, o_last_pixel_out};
                words_checked++;
                if (expected_pixels.size() == 0) begin
                    error_count++;
                    $display("%0t ns: unexpected pixel word r=%0d g=%0d b=%0d last=%0d",
                             $time, got.red, got.green, got.blue, got.last_flag);
                end else begin
                    want = expected_pixels.pop_front();
                    if (got !== want) begin
                        error_count++;
                        $display("%0t ns: pixel mismatch, expected r=%0d g=%0d b=%0d last=%0d",
                                 $time, want.red, want.green, want.blue, want.last_flag);
                        $display("%0t ns: actual r=%0d g=%0d b=%0d last=%0d",
                                 $time, got.red, got.green, got.blue, got.last_flag);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                stall_left = idle_gap();
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: cycle limit reached with %0d pixels outstanding",
                     $time, expected_pixels.size());
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int spectral_corners[$];
        int gray_corners[$];
        int phase_words;
        spectral_corners = '{-524288, -65536, -1, 0, 1, 2, 7864, 7865, 15728, 15729,
                             34078, 34079, 51118, 62259, 62260, 32768, 65535, 65536,
                             65537, 524287};
        gray_corners = '{-1, 0, 1, 257, 258, 32768, 65535, 65536, 524287};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The spectral map is checked first from its reset selection.
        foreach (spectral_corners[k]) push_height(HEIGHT_W'(spectral_corners[k]), k[0]);
        wait_drained();
        write_mode(1'b1);
        foreach (gray_corners[k]) push_height(HEIGHT_W'(gray_corners[k]), k[0]);
        wait_drained();

        phase_words = RANDOM_WORDS / PHASE_COUNT;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_mode(p[0] ? 1'b1 : 1'b0);
            quiet_phase = (p % 3 == 2);
            for (int k = 0; k < phase_words; k++)
                push_height(random_height(), ($urandom_range(0, 15) == 0));
            wait_drained();
        end

        $display("Sent %0d height words and checked %0d pixel words in both color modes,",
                 words_sent, words_checked);
        $display("with %0d mode writes and random idling on input and output.", mode_writes);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
